### rtl/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Shared constants and types of the printer serial packet engine.
// ----------------------------------------------------------------------------
package psp_pkg;

  // buffer sizes
  localparam int unsigned PayloadBytes = 640;
  localparam int unsigned ImageBytes   = 8000;
  localparam int unsigned PayAw        = $clog2(PayloadBytes);
  localparam int unsigned ImgAw        = $clog2(ImageBytes);

  // framing bytes
  localparam logic [7:0] SyncFirst  = 8'h88;
  localparam logic [7:0] SyncSecond = 8'h33;
  localparam logic [7:0] AckByte    = 8'h81;

  // command codes
  localparam logic [7:0] CmdInit   = 8'h01;
  localparam logic [7:0] CmdPrint  = 8'h02;
  localparam logic [7:0] CmdData   = 8'h04;
  localparam logic [7:0] CmdStatus = 8'h0f;

  // status masks
  localparam logic [7:0] StCsumErr   = 8'h01;
  localparam logic [7:0] StPrinting  = 8'h02;
  localparam logic [7:0] StRequested = 8'h04;
  localparam logic [7:0] StReady     = 8'h08;
  localparam logic [7:0] StPktErr    = 8'h10;

  localparam logic [7:0] PaletteReset   = 8'he4;
  localparam logic [7:0] TimeoutReset   = 8'd6;
  localparam logic [13:0] RowRound      = 14'd39;   // 40 bytes per row, minus one
  localparam logic [11:0] RowRecip      = 12'd3277; // 2^17 / 40, rounded up
  localparam int unsigned RowShift      = 17;
  localparam logic [9:0] MaxHeight      = 10'd208;

  typedef enum logic {
    JOB_TICK = 1'b0,
    JOB_EXEC = 1'b1
  } job_kind_e;

  // classified request from the framing front end
  typedef struct packed {
    job_kind_e   kind;
    logic        csum_ok;
    logic        len_bad;
    logic [7:0]  cmd;
    logic [7:0]  mode;
    logic [15:0] len;
  } job_t;

  // payload buffer write port
  typedef struct packed {
    logic             we;
    logic [PayAw-1:0] addr;
    logic [7:0]       data;
  } pay_wr_t;

endpackage

### rtl/psp_if.sv
// ----------------------------------------------------------------------------
// psp_in_if / psp_out_if
// Valid/ready channels of the printer serial packet engine.
// ----------------------------------------------------------------------------
interface psp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

interface psp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_byte;
  logic        print_start;
  logic [7:0]  print_height;
  logic [7:0]  print_palette;
  logic [12:0] image_length;

  modport source (output valid, output reply_byte, output print_start,
                  output print_height, output print_palette, output image_length,
                  input ready);
  modport sink   (input valid, input reply_byte, input print_start,
                  input print_height, input print_palette, input image_length,
                  output ready);
endinterface

### rtl/psp_front.sv
// ----------------------------------------------------------------------------
// psp_front
// Framing machine: takes requests, tracks the packet, fills the payload
// buffer and hands packet execution and ticks to the back end.
// ----------------------------------------------------------------------------
module psp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  psp_in_if.sink            req_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              fifo_empty_i,
  input  logic              back_idle_i,
  output logic              job_push_o,
  output psp_pkg::job_t     job_o,
  output psp_pkg::pay_wr_t  pay_wr_o,
  output logic              fr_valid_o,
  input  logic              fr_ready_i,
  output logic [7:0]        fr_reply_o
);
  import psp_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SYNC    = 4'd1;
  localparam logic [3:0] PH_CMD     = 4'd2;
  localparam logic [3:0] PH_MODE    = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_SUM_LO  = 4'd7;
  localparam logic [3:0] PH_SUM_HI  = 4'd8;
  localparam logic [3:0] PH_ACK     = 4'd9;
  localparam logic [3:0] PH_STATUS  = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d, mode_q, mode_d;
  logic [15:0] len_q, len_d, count_q, count_d, sum_q, sum_d, sent_q, sent_d;
  logic        len_bad_q, len_bad_d;
  logic [7:0]  idle_q, idle_d, timeout_q;
  logic        fr_valid_q, fr_valid_d;
  logic [7:0]  reply_q, reply_d;
  logic        accept;
  logic [7:0]  v;
  logic [15:0] full_len, count_inc;

  assign req_i.ready = !fr_valid_q && fifo_empty_i && back_idle_i;
  assign accept      = req_i.valid && req_i.ready;
  assign v           = req_i.byte_value;
  assign full_len    = {v, len_q[7:0]};
  assign count_inc   = count_q + 16'd1;

  // framing next state
  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    mode_d     = mode_q;
    len_d      = len_q;
    count_d    = count_q;
    sum_d      = sum_q;
    sent_d     = sent_q;
    len_bad_d  = len_bad_q;
    idle_d     = idle_q;
    fr_valid_d = fr_valid_q && !fr_ready_i;
    reply_d    = reply_q;
    job_push_o = 1'b0;
    job_o      = '{kind: JOB_TICK, csum_ok: (sum_q == sent_q), len_bad: len_bad_q,
                   cmd: cmd_q, mode: mode_q, len: len_q};
    pay_wr_o   = '{we: 1'b0, addr: count_q[PayAw-1:0], data: v};
    if (accept && req_i.operation) begin
      // tick: idle timeout, then the back end handles the print counter
      job_push_o = 1'b1;
      if (phase_q != PH_IDLE) begin
        idle_d = (idle_q == 8'hff) ? idle_q : idle_q + 8'd1;
        if (idle_d >= timeout_q) begin
          phase_d = PH_IDLE; len_d = '0; count_d = '0; sum_d = '0;
          sent_d = '0; idle_d = '0; len_bad_d = 1'b0;
        end
      end
    end else if (accept) begin
      idle_d     = '0;
      fr_valid_d = 1'b1;
      reply_d    = '0;
      unique case (phase_q)
        PH_IDLE: if (v == SyncFirst) phase_d = PH_SYNC;
        PH_SYNC: begin
          if (v == SyncSecond)     phase_d = PH_CMD;
          else if (v == SyncFirst) phase_d = PH_SYNC;
          else                     phase_d = PH_IDLE;
        end
        PH_CMD: begin
          cmd_d = v; sum_d = {8'd0, v}; phase_d = PH_MODE;
        end
        PH_MODE: begin
          mode_d = v; sum_d = sum_q + {8'd0, v}; phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d = {8'd0, v}; sum_d = sum_q + {8'd0, v}; phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d     = full_len;
          sum_d     = sum_q + {8'd0, v};
          count_d   = '0;
          len_bad_d = full_len > 16'(PayloadBytes);
          phase_d   = (full_len != '0) ? PH_PAYLOAD : PH_SUM_LO;
        end
        PH_PAYLOAD: begin
          sum_d       = sum_q + {8'd0, v};
          pay_wr_o.we = count_q < 16'(PayloadBytes);
          count_d     = count_inc;
          if (count_inc == len_q) phase_d = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          sent_d = {8'd0, v}; phase_d = PH_SUM_HI;
        end
        PH_SUM_HI: begin
          sent_d = {v, sent_q[7:0]}; phase_d = PH_ACK;
        end
        PH_ACK: begin
          reply_d = AckByte; phase_d = PH_STATUS;
        end
        PH_STATUS: begin
          // status reply and execution belong to the back end
          fr_valid_d  = 1'b0;
          job_push_o  = 1'b1;
          job_o.kind  = JOB_EXEC;
          phase_d = PH_IDLE; len_d = '0; count_d = '0; sum_d = '0;
          sent_d = '0; len_bad_d = 1'b0;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // framing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cmd_q      <= '0;
      mode_q     <= '0;
      len_q      <= '0;
      count_q    <= '0;
      sum_q      <= '0;
      sent_q     <= '0;
      len_bad_q  <= 1'b0;
      idle_q     <= '0;
      timeout_q  <= TimeoutReset;
      fr_valid_q <= 1'b0;
      reply_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      mode_q     <= mode_d;
      len_q      <= len_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      sent_q     <= sent_d;
      len_bad_q  <= len_bad_d;
      idle_q     <= idle_d;
      fr_valid_q <= fr_valid_d;
      reply_q    <= reply_d;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
    end
  end

  assign fr_valid_o = fr_valid_q;
  assign fr_reply_o = reply_q;

endmodule

### rtl/psp_job_fifo.sv
// ----------------------------------------------------------------------------
// psp_job_fifo
// Two-entry queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module psp_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  psp_pkg::job_t  data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output psp_pkg::job_t  data_o
);
  import psp_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

### rtl/psp_back.sv
// ----------------------------------------------------------------------------
// psp_back
// Packet executor: status reply, INIT/DATA/PRINT/STATUS handling with a
// validate-then-commit walk over the payload buffer, and the print counter.
// ----------------------------------------------------------------------------
module psp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  psp_pkg::job_t     job_i,
  output logic              job_pop_o,
  input  psp_pkg::pay_wr_t  pay_wr_i,
  output logic              idle_o,
  output logic              bk_valid_o,
  input  logic              bk_ready_i,
  output logic [7:0]        bk_reply_o,
  output logic              bk_start_o,
  output logic [7:0]        bk_height_o,
  output logic [7:0]        bk_palette_o,
  output logic [12:0]       bk_length_o
);
  import psp_pkg::*;

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_DECODE = 4'd1;
  localparam logic [3:0] B_PR_A   = 4'd2;
  localparam logic [3:0] B_PR_B   = 4'd3;
  localparam logic [3:0] B_PR_C   = 4'd4;
  localparam logic [3:0] B_PR_D   = 4'd5;
  localparam logic [3:0] B_CTL    = 4'd6;
  localparam logic [3:0] B_CTL_W  = 4'd7;
  localparam logic [3:0] B_LIT    = 4'd8;
  localparam logic [3:0] B_LIT_W  = 4'd9;
  localparam logic [3:0] B_RUN_W  = 4'd10;
  localparam logic [3:0] B_RUN    = 4'd11;

  logic [7:0]        pay_mem [PayloadBytes];
  logic [7:0]        img_mem [ImageBytes];
  logic [7:0]        rd_data_q;
  logic              img_we;
  logic [ImgAw-1:0]  img_addr;
  logic [7:0]        img_wdata;

  logic [3:0]        state_q, state_d;
  job_t              job_q, job_d;
  logic [7:0]        status_q, status_d, palette_q, palette_d, busy_q, busy_d;
  logic [12:0]       fill_q, fill_d;
  logic              empty_q, empty_d, commit_q, commit_d;
  logic [PayAw-1:0]  pos_q, pos_d, cnt_q, cnt_d;
  logic [13:0]       out_q, out_d;
  logic              bk_valid_q, bk_valid_d, start_q, start_d;
  logic [7:0]        reply_q, reply_d, height_q, height_d, pal_out_q, pal_out_d;
  logic [12:0]       length_q, length_d;

  logic [PayAw-1:0]  len_s, pos1, left_s;
  logic [13:0]       room, avail, n_lit, n_run, x_rows;
  logic [25:0]       prod;
  logic [8:0]        rows;
  logic [9:0]        hsum, height;
  logic [7:0]        busy_dec;
  logic [7:0]        ctl;

  assign len_s    = job_q.len[PayAw-1:0];
  assign room     = 14'(ImageBytes) - {1'b0, fill_q};
  assign avail    = room - out_q;
  assign ctl      = rd_data_q;
  assign pos1     = pos_q + PayAw'(1);
  assign left_s   = len_s - pos1;
  assign n_lit    = {7'd0, ctl[6:0]} + 14'd1;
  assign n_run    = {7'd0, ctl[6:0]} + 14'd2;
  assign busy_dec = busy_q - 8'd1;

  // printed height: rows of 40 bytes rounded up to 16
  assign x_rows = {1'b0, fill_q} + RowRound;
  assign prod   = x_rows * RowRecip;
  assign rows   = prod[25:RowShift];
  assign hsum   = {1'b0, rows} + 10'd15;
  assign height = {hsum[9:4], 4'd0};

  assign idle_o    = (state_q == B_IDLE) && !bk_valid_q;
  assign job_pop_o = idle_o && job_valid_i;

  // executor next state
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    status_d   = status_q;
    palette_d  = palette_q;
    busy_d     = busy_q;
    fill_d     = fill_q;
    empty_d    = empty_q;
    commit_d   = commit_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    out_d      = out_q;
    bk_valid_d = bk_valid_q && !bk_ready_i;
    reply_d    = reply_q;
    start_d    = start_q;
    height_d   = height_q;
    pal_out_d  = pal_out_q;
    length_d   = length_q;
    img_we     = 1'b0;
    img_addr   = ImgAw'(fill_q + out_q[12:0]);
    img_wdata  = rd_data_q;
    unique case (state_q)
      B_IDLE: begin
        if (job_pop_o) begin
          bk_valid_d = 1'b1;
          start_d    = 1'b0;
          height_d   = '0;
          pal_out_d  = '0;
          length_d   = '0;
          if (job_i.kind == JOB_EXEC) begin
            reply_d = status_q;
            job_d   = job_i;
            state_d = B_DECODE;
          end else begin
            reply_d = '0;
            // print counter
            if (busy_q != '0) begin
              busy_d = busy_dec;
              if (busy_dec == '0) begin
                if ((status_q & StPrinting) != '0) begin
                  status_d = status_q & ~StPrinting;
                end else if (height != '0 && height <= MaxHeight) begin
                  start_d   = 1'b1;
                  height_d  = height[7:0];
                  pal_out_d = palette_q;
                  length_d  = fill_q;
                  fill_d    = '0;
                  empty_d   = 1'b0;
                  status_d  = (status_q & ~(StReady | StPktErr)) | StRequested | StPrinting;
                  busy_d    = height[7:0];
                end
              end
            end
          end
        end
      end
      B_DECODE: begin
        state_d = B_IDLE;
        if (!job_q.csum_ok) begin
          status_d = status_q | StCsumErr;
        end else begin
          status_d = status_q & ~StCsumErr;
          priority if (job_q.len_bad || job_q.mode > 8'd1) begin
            status_d = status_d | StPktErr;
          end else if (job_q.cmd == CmdInit && job_q.len == '0) begin
            fill_d = '0; empty_d = 1'b0; status_d = '0; busy_d = '0;
          end else if (job_q.cmd == CmdData) begin
            if (busy_q != '0) begin
              status_d = status_d | StPktErr;
            end else if (job_q.mode == 8'd0) begin
              if (14'(len_s) > room) begin
                status_d = status_d | StPktErr;
              end else if (len_s == '0) begin
                empty_d  = 1'b1;
                status_d = status_d & ~StPktErr;
              end else begin
                commit_d = 1'b1; pos_d = '0; out_d = '0; cnt_d = len_s;
                state_d  = B_LIT;
              end
            end else begin
              commit_d = 1'b0; pos_d = '0; out_d = '0;
              state_d  = B_CTL;
            end
          end else if (job_q.cmd == CmdPrint && job_q.len == 16'd4) begin
            pos_d = '0; state_d = B_PR_A;
          end else if (job_q.cmd == CmdStatus && job_q.len == '0) begin
            status_d = status_d & ~StPktErr;
          end else begin
            status_d = status_d | StPktErr;
          end
        end
      end
      B_PR_A: state_d = B_PR_B;
      B_PR_B: begin
        pos_d    = PayAw'(2);
        state_d  = B_IDLE;
        if (rd_data_q == '0) begin
          status_d = status_q & ~StPktErr;
        end else if (rd_data_q != 8'd1 || fill_q == '0 || !empty_q || busy_q != '0) begin
          status_d = status_q | StPktErr;
        end else begin
          state_d = B_PR_C;
        end
      end
      B_PR_C: state_d = B_PR_D;
      B_PR_D: begin
        palette_d = rd_data_q;
        status_d  = status_q & ~StPktErr;
        busy_d    = 8'd1;
        state_d   = B_IDLE;
      end
      B_CTL: begin
        if (pos_q == len_s) begin
          state_d = B_IDLE;
          if (commit_q) begin
            fill_d   = fill_q + out_q[12:0];
            empty_d  = 1'b0;
            status_d = (status_q | StReady) & ~StPktErr;
          end else if (out_q == '0) begin
            empty_d  = 1'b1;
            status_d = status_q & ~StPktErr;
          end else begin
            commit_d = 1'b1; pos_d = '0; out_d = '0;
            state_d  = B_CTL;
          end
        end else begin
          state_d = B_CTL_W;
        end
      end
      B_CTL_W: begin
        if (!ctl[7]) begin
          // literal run of ctl+1 bytes
          if (!commit_q && (n_lit > 14'(left_s) || n_lit > avail)) begin
            status_d = status_q | StPktErr;
            state_d  = B_IDLE;
          end else if (!commit_q) begin
            pos_d = pos1 + PayAw'(n_lit); out_d = out_q + n_lit; state_d = B_CTL;
          end else begin
            pos_d = pos1; cnt_d = PayAw'(n_lit); state_d = B_LIT;
          end
        end else begin
          // repeated byte, ctl-0x80+2 times
          if (!commit_q && (pos1 == len_s || n_run > avail)) begin
            status_d = status_q | StPktErr;
            state_d  = B_IDLE;
          end else if (!commit_q) begin
            pos_d = pos1 + PayAw'(1); out_d = out_q + n_run; state_d = B_CTL;
          end else begin
            pos_d = pos1; cnt_d = PayAw'(n_run); state_d = B_RUN_W;
          end
        end
      end
      B_LIT: state_d = B_LIT_W;
      B_LIT_W: begin
        img_we  = 1'b1;
        pos_d   = pos1;
        out_d   = out_q + 14'd1;
        cnt_d   = cnt_q - PayAw'(1);
        state_d = (cnt_q == PayAw'(1)) ? B_CTL : B_LIT;
      end
      B_RUN_W: state_d = B_RUN;
      B_RUN: begin
        img_we = 1'b1;
        out_d  = out_q + 14'd1;
        cnt_d  = cnt_q - PayAw'(1);
        if (cnt_q == PayAw'(1)) begin
          pos_d   = pos1;
          state_d = B_CTL;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // executor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      status_q   <= '0;
      palette_q  <= PaletteReset;
      busy_q     <= '0;
      fill_q     <= '0;
      empty_q    <= 1'b0;
      commit_q   <= 1'b0;
      pos_q      <= '0;
      cnt_q      <= '0;
      out_q      <= '0;
      bk_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      status_q   <= status_d;
      palette_q  <= palette_d;
      busy_q     <= busy_d;
      fill_q     <= fill_d;
      empty_q    <= empty_d;
      commit_q   <= commit_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      out_q      <= out_d;
      bk_valid_q <= bk_valid_d;
    end
  end

  // payload of the job and the result
  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    reply_q   <= reply_d;
    start_q   <= start_d;
    height_q  <= height_d;
    pal_out_q <= pal_out_d;
    length_q  <= length_d;
  end

  // payload buffer: write from framing, registered read at the walk position
  always_ff @(posedge clk_i) begin
    if (pay_wr_i.we) pay_mem[pay_wr_i.addr] <= pay_wr_i.data;
    rd_data_q <= pay_mem[pos_q];
  end

  // image memory
  always_ff @(posedge clk_i) begin
    if (img_we) img_mem[img_addr] <= img_wdata;
  end

  assign bk_valid_o   = bk_valid_q;
  assign bk_reply_o   = reply_q;
  assign bk_start_o   = start_q;
  assign bk_height_o  = height_q;
  assign bk_palette_o = pal_out_q;
  assign bk_length_o  = length_q;

endmodule

### rtl/printer_serial_packet_engine.sv
// ----------------------------------------------------------------------------
// printer_serial_packet_engine
// Link-cable printer endpoint: framing front end, request queue, executor.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per serial byte (operation 0) or frame tick
//   (operation 1); rsp_o returns exactly one result per request, in order.
//   cfg_we_i/cfg_wdata_i write the idle timeout in ticks; the user must write it
//   only while the block idles, as the block itself does not enforce this.
//   A framing byte answers in the cycle after acceptance. A tick, or the
//   status byte ending a packet, goes through the request queue to the
//   executor, which answers and runs a packet: INIT/STATUS in B_DECODE,
//   PRINT in B_PR_A to B_PR_D. Run-length DATA first walks the controls
//   (B_CTL, B_CTL_W) to validate; the commit then copies literals (B_LIT,
//   B_LIT_W) and writes runs (B_RUN_W, B_RUN), paced by the single
//   registered read port of the payload buffer. A new request is taken only
//   once the previous result is delivered and the executor idles.
// Reset: framing idle, status clear, palette 0xe4, timeout 6; buffers kept.
// Stall: while rsp_o.ready is low the result holds and req_i.ready stays low.
// ----------------------------------------------------------------------------
module printer_serial_packet_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  psp_in_if.sink     req_i,
  psp_out_if.source  rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import psp_pkg::*;

  job_t       push_job, pop_job;
  pay_wr_t    pay_wr;
  logic       job_push, job_pop, fifo_valid, back_idle;
  logic       fr_valid, bk_valid, bk_start;
  logic [7:0] fr_reply, bk_reply, bk_height, bk_palette;
  logic [12:0] bk_length;

  psp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fifo_empty_i (!fifo_valid),
    .back_idle_i  (back_idle),
    .job_push_o   (job_push),
    .job_o        (push_job),
    .pay_wr_o     (pay_wr),
    .fr_valid_o   (fr_valid),
    .fr_ready_i   (rsp_o.ready),
    .fr_reply_o   (fr_reply)
  );

  psp_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (push_job),
    .pop_i   (job_pop),
    .valid_o (fifo_valid),
    .data_o  (pop_job)
  );

  psp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (fifo_valid),
    .job_i        (pop_job),
    .job_pop_o    (job_pop),
    .pay_wr_i     (pay_wr),
    .idle_o       (back_idle),
    .bk_valid_o   (bk_valid),
    .bk_ready_i   (rsp_o.ready),
    .bk_reply_o   (bk_reply),
    .bk_start_o   (bk_start),
    .bk_height_o  (bk_height),
    .bk_palette_o (bk_palette),
    .bk_length_o  (bk_length)
  );

  // only one result is ever outstanding, so a plain select merges them
  assign rsp_o.valid         = fr_valid || bk_valid;
  assign rsp_o.reply_byte    = bk_valid ? bk_reply : fr_reply;
  assign rsp_o.print_start   = bk_valid && bk_start;
  assign rsp_o.print_height  = bk_valid ? bk_height : 8'd0;
  assign rsp_o.print_palette = bk_valid ? bk_palette : 8'd0;
  assign rsp_o.image_length  = bk_valid ? bk_length : 13'd0;

endmodule
